// File: rtl/core/tbim_pkg.sv
// Shared types and constants for the two-body invariant mass pipeline.
// Used by tbim_trig, the top level and the bench; no dependencies.
package tbim_pkg;

	typedef struct packed {
		logic        [17:0] energy_first;
		logic        [14:0] polar_first;
		logic signed [15:0] azimuth_first;
		logic        [17:0] energy_second;
		logic        [14:0] polar_second;
		logic signed [15:0] azimuth_second;
		logic signed [15:0] focal_position;
	} in_t;

	typedef struct packed {
		logic signed [17:0] excitation_kev;
		logic               alpha_is_second;
	} out_t;

	localparam int CFG_IDX_W = 3;
	localparam int CFG_DATA_W = 24;
	localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_LOW    = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_HIGH   = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_MASS_ALPHA    = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_MASS_DEUTERON = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_MASS_PARENT   = 3'd4;

	localparam logic signed [15:0] RST_WINDOW_LOW  = -16'sd2200;
	localparam logic signed [15:0] RST_WINDOW_HIGH = -16'sd800;
	localparam logic [23:0] RST_MASS_ALPHA    = 24'd3727379;
	localparam logic [23:0] RST_MASS_DEUTERON = 24'd1875613;
	localparam logic [23:0] RST_MASS_PARENT   = 24'd5601518;

	// angle handling, centidegrees
	localparam logic [17:0] TURN_CD    = 18'd36000;
	localparam logic [17:0] QUARTER_CD = 18'd9000;
	localparam logic [13:0] EIGHTH_CD  = 14'd4500;
	// round(pi*2^30) = 18000*PI_HI + PI_LO
	localparam logic [17:0] PI_HI = 18'd187403;
	localparam logic [12:0] PI_LO = 13'd5426;
	localparam logic [24:0] HALF_DIV = 25'd9000;
	localparam int RECIP_CD_SH = 40;
	localparam logic [25:0] RECIP_CD = 26'(((64'd1 << 40) + 64'd17999) / 64'd18000);
	localparam logic [30:0] TRIG_ONE = 31'h4000_0000;

	// Taylor term divisors: floor(y/K) = (y*M) >> (30+L), exact for y < 2^30
	localparam int NTERM = 6;
	localparam int SIN_L [NTERM] = '{3, 5, 6, 7, 7, 8};
	localparam int COS_L [NTERM] = '{1, 4, 5, 6, 7, 8};
	localparam logic [31:0] SIN_M [NTERM] = '{
		32'(((64'd1 << 33) + 64'd5) / 64'd6),
		32'(((64'd1 << 35) + 64'd19) / 64'd20),
		32'(((64'd1 << 36) + 64'd41) / 64'd42),
		32'(((64'd1 << 37) + 64'd71) / 64'd72),
		32'(((64'd1 << 37) + 64'd109) / 64'd110),
		32'(((64'd1 << 38) + 64'd155) / 64'd156)
	};
	localparam logic [31:0] COS_M [NTERM] = '{
		32'(((64'd1 << 31) + 64'd1) / 64'd2),
		32'(((64'd1 << 34) + 64'd11) / 64'd12),
		32'(((64'd1 << 35) + 64'd29) / 64'd30),
		32'(((64'd1 << 36) + 64'd55) / 64'd56),
		32'(((64'd1 << 37) + 64'd89) / 64'd90),
		32'(((64'd1 << 38) + 64'd131) / 64'd132)
	};

	localparam int TRIG_LAT = 18;
	localparam int P_W = 52;
	localparam int M_W = 60;

	// Q30 product, truncated toward zero
	function automatic logic signed [31:0] mul_q(input logic signed [31:0] a,
		input logic signed [31:0] b);
		logic signed [63:0] p;
		logic signed [63:0] adj;
		logic signed [63:0] sh;
		p = 64'(a) * 64'(b);
		adj = (p < 0) ? p + 64'sd1073741823 : p;
		sh = adj >>> 30;
		return sh[31:0];
	endfunction

endpackage

// File: rtl/core/tbim_trig.sv
// Pipelined sine/cosine of a centidegree angle, Q30 results.
// Depends on tbim_pkg (angle constants, Taylor divisor reciprocals).
module tbim_trig (
	input  logic               clk,
	input  logic               ce,
	input  logic signed [16:0] angle,
	output logic signed [31:0] sin_val,
	output logic signed [31:0] cos_val
);
	import tbim_pkg::*;

	logic [17:0] amod_n, amod_s1;
	logic [1:0]  quad_n;
	logic [13:0] r0_n, rf_n;
	logic        fold_n;
	logic [12:0] r_s2;
	logic [2:0]  qf_s2, qf_s3, qf_s4;
	logic [29:0] base_s3, x_s4;
	logic [24:0] num_s3;

	logic [30:0]        tsin_q [NTERM+1];
	logic [30:0]        tcos_q [NTERM+1];
	logic signed [32:0] ssin_q [NTERM+1];
	logic signed [32:0] scos_q [NTERM+1];
	logic [29:0]        x2t_q  [NTERM+1];
	logic [2:0]         qft_q  [NTERM+1];
	logic [29:0]        ysin_q [NTERM];
	logic [29:0]        ycos_q [NTERM];
	logic signed [32:0] sysin_q [NTERM];
	logic signed [32:0] sycos_q [NTERM];
	logic [29:0]        x2y_q  [NTERM];
	logic [2:0]         qfy_q  [NTERM];

	logic [29:0] ysin_n [NTERM];
	logic [29:0] ycos_n [NTERM];
	logic [30:0] tsin_n [NTERM];
	logic [30:0] tcos_n [NTERM];

	function automatic logic [30:0] clamp_unit(input logic signed [32:0] s);
		if (s < 0)
			return '0;
		if (s > $signed({2'b00, TRIG_ONE}))
			return TRIG_ONE;
		return s[30:0];
	endfunction

	// reduce to [0, 36000)
	always_comb begin
		logic signed [18:0] wrap;
		logic [17:0] mu;
		wrap = 19'(angle) + 19'sd72000;
		mu = wrap[17:0];
		priority if (mu >= 18'd108000) amod_n = mu - 18'd108000;
		else if (mu >= 18'd72000) amod_n = mu - 18'd72000;
		else if (mu >= TURN_CD) amod_n = mu - TURN_CD;
		else amod_n = mu;
	end

	// quadrant and fold to [0, 45] degrees
	always_comb begin
		priority if (amod_s1 >= 18'd27000) begin
			quad_n = 2'd3;
			r0_n = 14'(amod_s1 - 18'd27000);
		end else if (amod_s1 >= 18'd18000) begin
			quad_n = 2'd2;
			r0_n = 14'(amod_s1 - 18'd18000);
		end else if (amod_s1 >= QUARTER_CD) begin
			quad_n = 2'd1;
			r0_n = 14'(amod_s1 - QUARTER_CD);
		end else begin
			quad_n = 2'd0;
			r0_n = 14'(amod_s1);
		end
		fold_n = r0_n > EIGHTH_CD;
		rf_n = fold_n ? 14'(QUARTER_CD) - r0_n : r0_n;
	end

	always_comb begin
		logic [60:0] ps;
		logic [60:0] pc;
		logic [61:0] ms;
		logic [61:0] mc;
		for (int i = 0; i < NTERM; i++) begin
			ps = 61'(tsin_q[i]) * 61'(x2t_q[i]);
			pc = 61'(tcos_q[i]) * 61'(x2t_q[i]);
			ysin_n[i] = ps[59:30];
			ycos_n[i] = pc[59:30];
			ms = 62'(ysin_q[i]) * 62'(SIN_M[i]);
			mc = 62'(ycos_q[i]) * 62'(COS_M[i]);
			tsin_n[i] = 31'(ms >> (30 + SIN_L[i]));
			tcos_n[i] = 31'(mc >> (30 + COS_L[i]));
		end
	end

	always_ff @(posedge clk) begin
		logic [50:0] qp;
		logic [59:0] xx;
		logic [30:0] bs;
		logic [30:0] bc;
		logic [30:0] tmp;
		if (ce) begin
			amod_s1 <= amod_n;
			r_s2 <= rf_n[12:0];
			qf_s2 <= {quad_n, fold_n};
			base_s3 <= 30'(31'(r_s2) * 31'(PI_HI));
			num_s3 <= 25'(r_s2) * 25'(PI_LO) + HALF_DIV;
			qf_s3 <= qf_s2;
			qp = 51'(num_s3) * 51'(RECIP_CD);
			x_s4 <= base_s3 + 30'(qp >> RECIP_CD_SH);
			qf_s4 <= qf_s3;
			xx = 60'(x_s4) * 60'(x_s4);
			x2t_q[0] <= xx[59:30];
			tsin_q[0] <= 31'(x_s4);
			ssin_q[0] <= 33'(x_s4);
			tcos_q[0] <= TRIG_ONE;
			scos_q[0] <= 33'(TRIG_ONE);
			qft_q[0] <= qf_s4;
			for (int i = 0; i < NTERM; i++) begin
				ysin_q[i] <= ysin_n[i];
				ycos_q[i] <= ycos_n[i];
				sysin_q[i] <= ssin_q[i];
				sycos_q[i] <= scos_q[i];
				x2y_q[i] <= x2t_q[i];
				qfy_q[i] <= qft_q[i];
				tsin_q[i+1] <= tsin_n[i];
				tcos_q[i+1] <= tcos_n[i];
				// odd terms subtract
				ssin_q[i+1] <= (i % 2 == 0) ? sysin_q[i] - 33'(tsin_n[i])
					: sysin_q[i] + 33'(tsin_n[i]);
				scos_q[i+1] <= (i % 2 == 0) ? sycos_q[i] - 33'(tcos_n[i])
					: sycos_q[i] + 33'(tcos_n[i]);
				x2t_q[i+1] <= x2y_q[i];
				qft_q[i+1] <= qfy_q[i];
			end
			bs = clamp_unit(ssin_q[NTERM]);
			bc = clamp_unit(scos_q[NTERM]);
			if (qft_q[NTERM][0]) begin
				tmp = bs;
				bs = bc;
				bc = tmp;
			end
			unique case (qft_q[NTERM][2:1])
				2'd0: begin
					sin_val <= $signed({1'b0, bs});
					cos_val <= $signed({1'b0, bc});
				end
				2'd1: begin
					sin_val <= $signed({1'b0, bc});
					cos_val <= -$signed({1'b0, bs});
				end
				2'd2: begin
					sin_val <= -$signed({1'b0, bs});
					cos_val <= -$signed({1'b0, bc});
				end
				default: begin
					sin_val <= -$signed({1'b0, bc});
					cos_val <= $signed({1'b0, bs});
				end
			endcase
		end
	end

endmodule

// File: rtl/core/tbim_isqrt.sv
// Pipelined rounded integer square root, one root bit per stage plus a rounding stage.
// No package dependency.
module tbim_isqrt #(
	parameter int W = 52
) (
	input  logic         clk,
	input  logic         ce,
	input  logic [W-1:0] radicand,
	output logic [W/2:0] root
);
	localparam int H = W / 2;

	logic [W:0]   rem_q [H];
	logic [H-1:0] q_q   [H];
	logic [W:0]   rem_n [H];
	logic [H-1:0] q_n   [H];

	// rem holds radicand - q^2; setting bit b costs (q << (b+1)) + 2^(2b)
	always_comb begin
		logic [W:0]   rs;
		logic [H-1:0] qs;
		logic [W:0]   inc;
		for (int k = 0; k < H; k++) begin
			rs = (k == 0) ? (W+1)'(radicand) : rem_q[(k == 0) ? 0 : k-1];
			qs = (k == 0) ? '0 : q_q[(k == 0) ? 0 : k-1];
			inc = ((W+1)'(qs) << (H - k)) + ((W+1)'(1) << (2 * (H - 1 - k)));
			if (rs >= inc) begin
				rem_n[k] = rs - inc;
				q_n[k] = qs | (H'(1) << (H - 1 - k));
			end else begin
				rem_n[k] = rs;
				q_n[k] = qs;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ce) begin
			for (int k = 0; k < H; k++) begin
				rem_q[k] <= rem_n[k];
				q_q[k] <= q_n[k];
			end
			root <= (H+1)'(q_q[H-1]) + (H+1)'(rem_q[H-1] > (W+1)'(q_q[H-1]));
		end
	end

endmodule

// File: rtl/core/two_body_invariant_mass_excitation.sv
// Top level: two-hit event in, excitation energy out, fully pipelined.
// Depends on tbim_pkg, tbim_trig and tbim_isqrt.
//
//  channel  | handshake              | payload
//  ---------+------------------------+---------------------------------
//  in       | in_valid / in_stall    | in_data  (tbim_pkg::in_t)
//  out      | out_valid / out_stall  | out_data (tbim_pkg::out_t)
//  cfg      | cfg_valid / cfg_ready  | cfg_index, cfg_data
//
// One event per cycle unless a held output stalls the pipe; the depth is set by the two square-root
// chains in series (26 + 30 root bits, one per stage); the 18-stage sine/cosine unit runs beside the momentum roots.
// Dropped events (outside the window, equal energies) ride the pipe and give no transfer.
// arst_n clears the valid line and loads register defaults; no clearing pass.
// out_stall with a result waiting freezes every stage and raises in_stall.
// cfg_ready is always high.
module two_body_invariant_mass_excitation #(
	parameter int FRAC_BITS = 16
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [tbim_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [tbim_pkg::CFG_DATA_W-1:0]   cfg_data,
	input  logic                              in_valid,
	output logic                              in_stall,
	input  tbim_pkg::in_t                     in_data,
	output logic                              out_valid,
	input  logic                              out_stall,
	output tbim_pkg::out_t                    out_data
);
	import tbim_pkg::*;

	// stage numbers of the main landmarks
	localparam int S_TRIG = 1 + TRIG_LAT;       // trig results
	localparam int S_CM   = S_TRIG + 4;         // rounded |cos psi|
	localparam int S_P    = 2 + P_W / 2 + 1;    // momenta
	localparam int S_DOT  = S_P + 3;            // pa*pd*|cos|
	localparam int S_M2   = S_DOT + 1;          // squared mass
	localparam int S_MQ   = S_M2 + M_W / 2 + 1; // mass, Q4
	localparam int S_OUT  = S_MQ + 1;
	localparam int CM_DLY = S_P - S_CM;
	localparam int SS_DLY = S_DOT - 3;
	localparam int UW = 28 + FRAC_BITS;
	localparam logic signed [29:0] EXC_HI = 30'sd131071;
	localparam logic signed [29:0] EXC_LO = -30'sd131072;

	// configuration
	logic signed [15:0] window_low_q, window_high_q;
	logic [23:0] mass_alpha_q, mass_deuteron_q, mass_parent_q;

	logic ce;

	logic vld_q  [1:S_OUT];
	logic keep_q [1:S_OUT];
	logic sec_q  [1:S_OUT];

	logic [17:0]        ka_s1, kd_s1;
	logic signed [16:0] ang1_s1, ang2_s1, angd_s1;

	logic signed [31:0] st1, ct1, st2, ct2, sd, cd;

	logic [43:0] pa2_s2, pd2_s2;
	logic [47:0] ma2_s2, md2_s2;
	logic [49:0] eaed_s2;
	logic [51:0] ssum_d [SS_DLY+1];

	logic signed [31:0] ps_s20, pc_s20, cd_s20, pps_s21, pc_s21;
	logic signed [32:0] v_s22;
	logic [FRAC_BITS:0] cm_d  [CM_DLY+1];
	logic               neg_d [CM_DLY+1];
	logic [FRAC_BITS:0] cm_n;

	logic [26:0]    pqa, pqd, pqd_s30;
	logic [UW-1:0]  u2_s30;
	logic           neg_s30, neg_s31, neg_s32;
	logic [54:0]    hi_s31;
	logic [26:0]    lo_s31;
	logic [55:0]    dot_s32;
	logic [M_W-1:0] m2_s33, m2_n;
	logic [30:0]    mq;
	logic signed [17:0] exc_s65, exc_n;

	assign cfg_ready = 1'b1;
	assign ce = !(out_valid && out_stall);
	assign in_stall = !ce;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_low_q <= RST_WINDOW_LOW;
			window_high_q <= RST_WINDOW_HIGH;
			mass_alpha_q <= RST_MASS_ALPHA;
			mass_deuteron_q <= RST_MASS_DEUTERON;
			mass_parent_q <= RST_MASS_PARENT;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				CFG_WINDOW_LOW: window_low_q <= $signed(cfg_data[15:0]);
				CFG_WINDOW_HIGH: window_high_q <= $signed(cfg_data[15:0]);
				CFG_MASS_ALPHA: mass_alpha_q <= cfg_data;
				CFG_MASS_DEUTERON: mass_deuteron_q <= cfg_data;
				CFG_MASS_PARENT: mass_parent_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// valid line, the only state reset clears
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 1; i <= S_OUT; i++)
				vld_q[i] <= 1'b0;
		end else if (ce) begin
			vld_q[1] <= in_valid;
			for (int i = 2; i <= S_OUT; i++)
				vld_q[i] <= vld_q[i-1];
		end
	end

	// s1: gate, pick alpha, form angles
	always_ff @(posedge clk) begin
		if (ce) begin
			keep_q[1] <= (in_data.focal_position > window_low_q)
				&& (in_data.focal_position < window_high_q)
				&& (in_data.energy_first != in_data.energy_second);
			sec_q[1] <= in_data.energy_second < in_data.energy_first;
			ka_s1 <= (in_data.energy_second < in_data.energy_first)
				? in_data.energy_second : in_data.energy_first;
			kd_s1 <= (in_data.energy_second < in_data.energy_first)
				? in_data.energy_first : in_data.energy_second;
			ang1_s1 <= $signed({2'b00, in_data.polar_first});
			ang2_s1 <= $signed({2'b00, in_data.polar_second});
			angd_s1 <= 17'(in_data.azimuth_first) - 17'(in_data.azimuth_second);
			for (int i = 2; i <= S_OUT; i++) begin
				keep_q[i] <= keep_q[i-1];
				sec_q[i] <= sec_q[i-1];
			end
		end
	end

	tbim_trig u_trig_t1 (.clk(clk), .ce(ce), .angle(ang1_s1), .sin_val(st1), .cos_val(ct1));
	tbim_trig u_trig_t2 (.clk(clk), .ce(ce), .angle(ang2_s1), .sin_val(st2), .cos_val(ct2));
	tbim_trig u_trig_d  (.clk(clk), .ce(ce), .angle(angd_s1), .sin_val(sd), .cos_val(cd));

	// s2..s3: p^2 per hit and the energy sum
	always_ff @(posedge clk) begin
		logic [25:0] sa;
		logic [25:0] sdt;
		logic [24:0] ea;
		logic [24:0] ed;
		if (ce) begin
			sa = 26'(ka_s1) + 26'({mass_alpha_q, 1'b0});
			sdt = 26'(kd_s1) + 26'({mass_deuteron_q, 1'b0});
			ea = 25'(ka_s1) + 25'(mass_alpha_q);
			ed = 25'(kd_s1) + 25'(mass_deuteron_q);
			pa2_s2 <= 44'(ka_s1) * 44'(sa);
			pd2_s2 <= 44'(kd_s1) * 44'(sdt);
			ma2_s2 <= 48'(mass_alpha_q) * 48'(mass_alpha_q);
			md2_s2 <= 48'(mass_deuteron_q) * 48'(mass_deuteron_q);
			eaed_s2 <= 50'(ea) * 50'(ed);
			ssum_d[0] <= 52'(ma2_s2) + 52'(md2_s2) + 52'({eaed_s2, 1'b0});
			for (int i = 1; i <= SS_DLY; i++)
				ssum_d[i] <= ssum_d[i-1];
		end
	end

	// momenta in Q4
	tbim_isqrt #(.W(P_W)) u_sqrt_a (.clk(clk), .ce(ce), .radicand({pa2_s2, 8'b0}),
		.root(pqa));
	tbim_isqrt #(.W(P_W)) u_sqrt_d (.clk(clk), .ce(ce), .radicand({pd2_s2, 8'b0}),
		.root(pqd));

	// |cos psi| rounded to FRAC_BITS, clamped to one
	always_comb begin
		logic [32:0] ua;
		logic [31:0] u;
		logic [32:0] cr;
		ua = (v_s22 < 0) ? 33'(-v_s22) : 33'(v_s22);
		u = ua[31:0];
		cr = (33'(u) + (33'(1) << (29 - FRAC_BITS))) >> (30 - FRAC_BITS);
		if (cr > (33'(1) << FRAC_BITS))
			cm_n = (FRAC_BITS+1)'(1) << FRAC_BITS;
		else
			cm_n = cr[FRAC_BITS:0];
	end

	// s20..s23: cos psi = st1*st2*cd + ct1*ct2
	always_ff @(posedge clk) begin
		if (ce) begin
			ps_s20 <= mul_q(st1, st2);
			pc_s20 <= mul_q(ct1, ct2);
			cd_s20 <= cd;
			pps_s21 <= mul_q(ps_s20, cd_s20);
			pc_s21 <= pc_s20;
			v_s22 <= 33'(pps_s21) + 33'(pc_s21);
			cm_d[0] <= cm_n;
			neg_d[0] <= v_s22 < 0;
			for (int i = 1; i <= CM_DLY; i++) begin
				cm_d[i] <= cm_d[i-1];
				neg_d[i] <= neg_d[i-1];
			end
		end
	end

	// squared mass, Q8 keV^2, clamped at zero
	always_comb begin
		logic signed [61:0] base;
		logic signed [61:0] twod;
		logic signed [61:0] m2v;
		base = $signed({2'b00, ssum_d[SS_DLY], 8'b0});
		twod = $signed({5'b0, dot_s32, 1'b0});
		m2v = neg_s32 ? base + twod : base - twod;
		m2_n = (m2v < 0) ? '0 : m2v[M_W-1:0];
	end

	// s30..s33: pa*pd*|cos| floored to Q8, then M^2
	always_ff @(posedge clk) begin
		logic [FRAC_BITS+26:0] lp;
		if (ce) begin
			u2_s30 <= UW'(pqa) * UW'(cm_d[CM_DLY]);
			pqd_s30 <= pqd;
			neg_s30 <= neg_d[CM_DLY];
			hi_s31 <= 55'(u2_s30[UW-1:FRAC_BITS]) * 55'(pqd_s30);
			lp = (FRAC_BITS+27)'(u2_s30[FRAC_BITS-1:0]) * (FRAC_BITS+27)'(pqd_s30);
			lo_s31 <= lp[FRAC_BITS+26:FRAC_BITS];
			neg_s31 <= neg_s30;
			dot_s32 <= 56'(hi_s31) + 56'(lo_s31);
			neg_s32 <= neg_s31;
			m2_s33 <= m2_n;
		end
	end

	tbim_isqrt #(.W(M_W)) u_sqrt_m (.clk(clk), .ce(ce), .radicand(m2_s33), .root(mq));

	// whole keV, minus parent mass, saturated
	always_comb begin
		logic [31:0] mr;
		logic signed [29:0] ev;
		mr = 32'(mq) + 32'd8;
		ev = $signed({2'b00, mr[31:4]}) - $signed({6'b0, mass_parent_q});
		priority if (ev > EXC_HI) exc_n = EXC_HI[17:0];
		else if (ev < EXC_LO) exc_n = EXC_LO[17:0];
		else exc_n = ev[17:0];
	end

	always_ff @(posedge clk) begin
		if (ce)
			exc_s65 <= exc_n;
	end

	assign out_valid = vld_q[S_OUT] && keep_q[S_OUT];
	always_comb begin
		out_data.excitation_kev = exc_s65;
		out_data.alpha_is_second = sec_q[S_OUT];
	end

`ifndef NO_ASSERTIONS
	a_enter: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> vld_q[1])
		else $error("accepted event missing from first stage");
	a_deliver: assert property (@(posedge clk) disable iff (!arst_n)
		(ce && vld_q[S_OUT-1] && keep_q[S_OUT-1]) |=> out_valid)
		else $error("kept event did not reach the output");
	a_drop: assert property (@(posedge clk) disable iff (!arst_n)
		(ce && !(vld_q[S_OUT-1] && keep_q[S_OUT-1])) |=> !out_valid)
		else $error("output raised without a kept event");
`endif

endmodule

// File: bench/two_body_invariant_mass_excitation_test.sv
`timescale 1ns / 1ps
// Self-checking bench for two_body_invariant_mass_excitation: directed table, then random events.
// Depends on tbim_pkg and the top level; holds its own bit-exact predictor of the result.
module two_body_invariant_mass_excitation_test;
	import tbim_pkg::*;

	localparam int FRAC = 16;
	localparam int QB = 30;
	localparam longint QONE = 64'sd1 << QB;
	localparam longint PI_Q = 64'sd3373259426;
	localparam longint FULL_TURN = 36000;
	localparam longint RIGHT_ANG = 9000;
	localparam longint HALF_RIGHT = 4500;
	localparam int PF = 4;
	localparam longint SAT_HI = 131071;
	localparam longint SAT_LO = -131072;
	localparam int SETTLE = 80;

	typedef enum logic [1:0] {ROW_CFG, ROW_PRED, ROW_DROP, ROW_VAL} row_kind_t;

	typedef struct {
		row_kind_t kind;
		in_t ev;
		logic [CFG_IDX_W-1:0] idx;
		logic [CFG_DATA_W-1:0] data;
		out_t val;
	} row_t;

	logic clk;
	logic arst_n;
	logic cfg_valid;
	logic cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;
	logic in_valid;
	logic in_stall;
	in_t in_data;
	logic out_valid;
	logic out_stall;
	out_t out_data;

	two_body_invariant_mass_excitation #(.FRAC_BITS(FRAC)) dut (
		.clk(clk), .arst_n(arst_n),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
		.out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
	);

	// predictor copy of the registers
	longint win_lo = RST_WINDOW_LOW;
	longint win_hi = RST_WINDOW_HIGH;
	longint unsigned m_alpha = RST_MASS_ALPHA;
	longint unsigned m_deut = RST_MASS_DEUTERON;
	longint unsigned m_parent = RST_MASS_PARENT;

	out_t excitation_q[$];	// results still owed by the block
	row_t sent_tags[$];		// how each offered event is to be judged
	row_t dir_tab[$];
	int errors = 0;
	bit calm = 0;			// no idling on either side
	bit hold_req = 0;

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// ---------------- predictor ----------------
	function automatic longint unsigned root_rnd(longint unsigned n);
		longint unsigned r, b, rem;
		r = 0;
		b = 64'd1 << 62;
		rem = n;
		while (b > rem) b >>= 2;
		while (b != 0) begin
			if (rem >= r + b) begin
				rem -= r + b;
				r = (r >> 1) + b;
			end else begin
				r >>= 1;
			end
			b >>= 2;
		end
		if (n - r * r > r) r++;
		return r;
	endfunction

	function automatic longint unit_clamp(longint s);
		if (s < 0) return 0;
		if (s > QONE) return QONE;
		return s;
	endfunction

	// Taylor series, each term truncated; sine when odd_series, else cosine
	function automatic longint taylor(longint unsigned x, bit odd_series);
		longint unsigned x2, t, k;
		longint s;
		x2 = (x * x) >> QB;
		t = odd_series ? x : longint'(QONE);
		s = odd_series ? longint'(x) : QONE;
		for (int n = 1; n <= 6; n++) begin
			k = odd_series ? longint'((2 * n) * (2 * n + 1)) : longint'((2 * n - 1) * (2 * n));
			t = ((t * x2) >> QB) / k;
			if (n % 2 == 1) s -= longint'(t);
			else s += longint'(t);
		end
		return unit_clamp(s);
	endfunction

	function automatic void sin_cos_cd(longint cdeg, output longint sn, output longint cs);
		longint a, q, r, bs, bc, tmp;
		longint unsigned x;
		bit fold;
		a = cdeg % FULL_TURN;
		if (a < 0) a += FULL_TURN;
		q = a / RIGHT_ANG;
		r = a % RIGHT_ANG;
		fold = r > HALF_RIGHT;
		if (fold) r = RIGHT_ANG - r;
		x = longint'((r * PI_Q + 9000) / 18000);
		bs = taylor(x, 1'b1);
		bc = taylor(x, 1'b0);
		if (fold) begin
			tmp = bs;
			bs = bc;
			bc = tmp;
		end
		case (q)
			0: begin sn = bs; cs = bc; end
			1: begin sn = bc; cs = -bs; end
			2: begin sn = -bs; cs = -bc; end
			default: begin sn = -bc; cs = bs; end
		endcase
	endfunction

	function automatic longint qmul(longint a, longint b);
		return (a * b) / QONE;
	endfunction

	// excitation of one event; returns 0 when the event is dropped
	function automatic bit excitation_of(in_t d, output out_t res);
		longint unsigned e1, e2, ka, kd, ea, ed, pqa, pqd, ssum, cm, u, uh, ul, dot, mq, mkev;
		longint st1, ct1, st2, ct2, sd, cd, v, m2, exc, focal;
		bit second, neg;
		res = '0;
		e1 = d.energy_first;
		e2 = d.energy_second;
		focal = longint'(d.focal_position);
		if (!(focal > win_lo && focal < win_hi)) return 0;
		if (e1 == e2) return 0;
		second = e2 < e1;
		ka = second ? e2 : e1;
		kd = second ? e1 : e2;
		ea = ka + m_alpha;
		ed = kd + m_deut;
		pqa = root_rnd((ka * (ka + 2 * m_alpha)) << (2 * PF));
		pqd = root_rnd((kd * (kd + 2 * m_deut)) << (2 * PF));
		ssum = m_alpha * m_alpha + m_deut * m_deut + 2 * ea * ed;
		sin_cos_cd(longint'(d.polar_first), st1, ct1);
		sin_cos_cd(longint'(d.polar_second), st2, ct2);
		sin_cos_cd(longint'(d.azimuth_first) - longint'(d.azimuth_second), sd, cd);
		v = qmul(qmul(st1, st2), cd) + qmul(ct1, ct2);
		neg = v < 0;
		u = neg ? longint'(-v) : longint'(v);
		cm = (u + (64'd1 << (QB - 1 - FRAC))) >> (QB - FRAC);
		if (cm > (64'd1 << FRAC)) cm = 64'd1 << FRAC;
		u = pqa * cm;
		uh = u >> FRAC;
		ul = u & ((64'd1 << FRAC) - 1);
		dot = uh * pqd + ((ul * pqd) >> FRAC);
		m2 = longint'(ssum << (2 * PF));
		if (neg) m2 += 2 * longint'(dot);
		else m2 -= 2 * longint'(dot);
		if (m2 < 0) m2 = 0;	// negative squared mass clamps
		mq = root_rnd(longint'(m2));
		mkev = (mq + (64'd1 << (PF - 1))) >> PF;
		exc = longint'(mkev) - longint'(m_parent);
		if (exc > SAT_HI) exc = SAT_HI;
		if (exc < SAT_LO) exc = SAT_LO;
		res.excitation_kev = exc[17:0];
		res.alpha_is_second = second;
		return 1;
	endfunction

	function automatic void apply_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
		case (idx)
			CFG_WINDOW_LOW: win_lo = longint'($signed(data[15:0]));
			CFG_WINDOW_HIGH: win_hi = longint'($signed(data[15:0]));
			CFG_MASS_ALPHA: m_alpha = data;
			CFG_MASS_DEUTERON: m_deut = data;
			CFG_MASS_PARENT: m_parent = data;
			default: ;	// unknown index: ignored
		endcase
	endfunction

	// ---------------- monitor: all sampling at the rising edge ----------------
	always @(posedge clk) begin : watch
		row_t tag;
		out_t pred;
		out_t want;
		bit hit;
		if (arst_n) begin
			if (cfg_valid && cfg_ready) apply_reg(cfg_index, cfg_data);
			if (in_valid && !in_stall) begin
				tag = sent_tags.pop_front();
				hit = excitation_of(in_data, pred);
				case (tag.kind)
					ROW_DROP: if (hit) begin
						$display("%0t event should drop, predictor keeps it: exc %0d",
							$time, pred.excitation_kev);
						errors++;
					end
					ROW_VAL: excitation_q.push_back(tag.val);
					default: if (hit) excitation_q.push_back(pred);
				endcase
			end
			if (out_valid && !out_stall) begin
				if (excitation_q.size() == 0) begin
					$display("%0t unexpected result: exc %0d alpha_is_second %0b",
						$time, out_data.excitation_kev, out_data.alpha_is_second);
					errors++;
				end else begin
					want = excitation_q.pop_front();
					if (out_data.excitation_kev !== want.excitation_kev) begin
						$display("%0t excitation_kev mismatch: expected %0d actual %0d",
							$time, want.excitation_kev, out_data.excitation_kev);
						errors++;
					end
					if (out_data.alpha_is_second !== want.alpha_is_second) begin
						$display("%0t alpha_is_second mismatch: expected %0b actual %0b",
							$time, want.alpha_is_second, out_data.alpha_is_second);
						errors++;
					end
				end
			end
		end
	end

	// mostly short gaps, a few long ones
	function automatic int pick_gap();
		int r;
		if (calm) return 0;
		r = $urandom_range(0, 99);
		if (r < 55) return 0;
		if (r < 90) return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	// ---------------- receiver ----------------
	initial begin : receiver
		int n;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (hold_req) begin
				// long hold-off so the pipe fills and in_stall rises
				out_stall <= 1'b1;
				repeat (400) @(negedge clk);
				hold_req = 0;
				out_stall <= 1'b0;
			end else begin
				n = pick_gap();
				out_stall <= (n > 0);
				repeat (n) @(negedge clk);
				if (n > 0) out_stall <= 1'b0;
				repeat ($urandom_range(0, 5)) @(negedge clk);
			end
		end
	end

	// ---------------- sender side, all called at a falling edge ----------------
	task automatic send_event(in_t d, row_t tag);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		sent_tags.push_back(tag);
		in_valid <= 1'b1;
		in_data <= d;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		@(negedge clk);
	endtask

	// wait out every owed result, plus the pipe depth for dropped events
	task automatic drain();
		in_valid <= 1'b0;
		while (excitation_q.size() != 0) @(negedge clk);
		repeat (SETTLE) @(negedge clk);
	endtask

	// one register transfer, then cfg_valid is dropped and the channel left idle
	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		@(negedge clk);
		cfg_valid <= 1'b0;
		@(negedge clk);
	endtask

	function automatic in_t mk_ev(int e1, int t1, int f1, int e2, int t2, int f2, int pos);
		in_t d;
		d.energy_first = e1;
		d.polar_first = t1;
		d.azimuth_first = f1;
		d.energy_second = e2;
		d.polar_second = t2;
		d.azimuth_second = f2;
		d.focal_position = pos;
		return d;
	endfunction

	function automatic void add_ev(row_kind_t k, in_t d, logic signed [17:0] x = 0, bit s = 0);
		row_t r;
		r.kind = k;
		r.ev = d;
		r.idx = '0;
		r.data = '0;
		r.val.excitation_kev = x;
		r.val.alpha_is_second = s;
		dir_tab.push_back(r);
	endfunction

	function automatic void add_cfg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
		row_t r;
		r = '{kind: ROW_CFG, ev: '0, idx: idx, data: data, val: '0};
		dir_tab.push_back(r);
	endfunction

	function automatic logic [17:0] rand_energy();
		int r;
		r = $urandom_range(0, 99);
		if (r < 70) return 18'($urandom);
		if (r < 88) return 18'($urandom_range(0, 4000));
		return $urandom_range(0, 1) ? 18'h3FFFF : 18'h0;
	endfunction

	function automatic in_t rand_event();
		in_t d;
		longint span;
		int r;
		d.energy_first = rand_energy();
		d.energy_second = ($urandom_range(0, 99) < 4) ? d.energy_first : rand_energy();
		d.polar_first = ($urandom_range(0, 99) < 85) ? 15'($urandom_range(0, 18000)) : 15'($urandom);
		d.polar_second = ($urandom_range(0, 99) < 85) ? 15'($urandom_range(0, 18000)) : 15'($urandom);
		d.azimuth_first = ($urandom_range(0, 99) < 85) ?
			16'($signed($urandom_range(0, 36000)) - 18000) : 16'($urandom);
		d.azimuth_second = ($urandom_range(0, 99) < 85) ?
			16'($signed($urandom_range(0, 36000)) - 18000) : 16'($urandom);
		span = win_hi - win_lo;
		r = $urandom_range(0, 99);
		if (r < 85 && span >= 2)
			d.focal_position = 16'(win_lo + 1 + longint'($urandom_range(0, int'(span - 2))));
		else if (r < 92)
			d.focal_position = $urandom_range(0, 1) ? 16'(win_lo) : 16'(win_hi);
		else
			d.focal_position = 16'($urandom);
		return d;
	endfunction

	task automatic random_run(int n);
		row_t tag;
		tag = '{kind: ROW_PRED, ev: '0, idx: '0, data: '0, val: '0};
		repeat (n) send_event(rand_event(), tag);
	endtask

	task automatic set_regs(int lo, int hi, int ma, int md, int mp);
		write_reg(CFG_WINDOW_LOW, 24'(lo));
		write_reg(CFG_WINDOW_HIGH, 24'(hi));
		write_reg(CFG_MASS_ALPHA, 24'(ma));
		write_reg(CFG_MASS_DEUTERON, 24'(md));
		write_reg(CFG_MASS_PARENT, 24'(mp));
	endtask

	// ---------------- run-time limit ----------------
	initial begin
		#30ms;
		$display("[two_body_invariant_mass_excitation] ERROR");
		$finish;
	end

	// ---------------- main sequence ----------------
	initial begin : main
		int lo, hi, ma, md, mp;
		clk = 1'b0;
		arst_n = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		in_valid = 1'b0;
		in_data = '0;
		out_stall = 1'b0;

		// directed rows, reset registers first
		add_ev(ROW_DROP, mk_ev(0, 0, 0, 0, 0, 0, -1500));			// equal energies
		add_ev(ROW_DROP, mk_ev(262143, 9000, 0, 262143, 9000, 0, -1500));
		add_ev(ROW_DROP, mk_ev(1000, 6000, 100, 2000, 7000, -100, -2200));	// on low bound
		add_ev(ROW_DROP, mk_ev(1000, 6000, 100, 2000, 7000, -100, -800));	// on high bound
		add_ev(ROW_PRED, mk_ev(1000, 6000, 100, 2000, 7000, -100, -2199));
		add_ev(ROW_PRED, mk_ev(2000, 6000, 100, 1000, 7000, -100, -801));
		add_ev(ROW_PRED, mk_ev(0, 0, 0, 262143, 18000, 18000, -1500));
		add_ev(ROW_PRED, mk_ev(262143, 18000, -18000, 0, 0, 0, -1500));
		add_ev(ROW_PRED, mk_ev(5000, 4500, 4500, 7000, 4501, -4499, -1500));	// fold edge
		add_ev(ROW_PRED, mk_ev(1, 9000, 9000, 2, 27000, -9000, -1500));
		add_ev(ROW_PRED, mk_ev(100000, 32767, -32768, 50000, 0, 32767, -1500));	// beyond a turn
		add_ev(ROW_PRED, mk_ev(3000, 12000, 16000, 4000, 12000, 16000, -1500));	// same direction
		add_cfg(3'd5, 24'hFFFFFF);	// unknown indexes, ignored
		add_cfg(3'd7, 24'h000000);
		add_ev(ROW_PRED, mk_ev(30000, 2500, 700, 80000, 14000, -9000, -1000));
		add_cfg(CFG_WINDOW_LOW, 24'hFF8AD0);	// -30000, upper bits set
		add_cfg(CFG_WINDOW_HIGH, 24'h007530);	// 30000
		add_ev(ROW_DROP, mk_ev(1000, 100, 0, 2000, 200, 0, 30000));
		add_ev(ROW_DROP, mk_ev(1000, 100, 0, 2000, 200, 0, -30000));
		add_cfg(CFG_MASS_ALPHA, 24'h000000);
		add_cfg(CFG_MASS_DEUTERON, 24'h000000);
		add_ev(ROW_PRED, mk_ev(5000, 3000, 0, 6000, 3000, 0, 0));	// squared mass near zero
		// huge masses, parent zero: top saturation
		add_cfg(CFG_MASS_ALPHA, 24'hFFFFFF);
		add_cfg(CFG_MASS_DEUTERON, 24'hFFFFFF);
		add_cfg(CFG_MASS_PARENT, 24'h000000);
		add_ev(ROW_VAL, mk_ev(10, 500, 0, 20, 900, 0, 0), 18'sd131071, 1'b0);
		add_ev(ROW_VAL, mk_ev(20, 500, 0, 10, 900, 0, 0), 18'sd131071, 1'b1);
		// no masses, parent at its top: bottom saturation
		add_cfg(CFG_MASS_ALPHA, 24'h000000);
		add_cfg(CFG_MASS_DEUTERON, 24'h000000);
		add_cfg(CFG_MASS_PARENT, 24'hFFFFFF);
		add_ev(ROW_VAL, mk_ev(262143, 0, 0, 262142, 18000, 0, 0), -18'sd131072, 1'b1);

		repeat (6) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		foreach (dir_tab[i]) begin
			if (dir_tab[i].kind == ROW_CFG) begin
				drain();
				write_reg(dir_tab[i].idx, dir_tab[i].data);
			end else begin
				send_event(dir_tab[i].ev, dir_tab[i]);
			end
		end

		// random phases
		drain();
		set_regs(-2200, -800, 3727379, 1875613, 5601518);
		random_run(300);

		drain();
		set_regs(-30000, 30000, 0, 0, 0);
		random_run(200);

		drain();
		set_regs(-30000, 30000, 16777215, 16777215, 16777215);
		random_run(200);

		// physical-ish random masses; receiver holds off while events keep coming
		drain();
		lo = $urandom_range(0, 40000) - 30000;
		hi = lo + $urandom_range(200, 30000 - lo);
		ma = $urandom_range(1000000, 16000000);
		md = $urandom_range(1000000, 8000000);
		mp = ma + md + $urandom_range(0, 200000) - 100000;
		if (mp > 16777215) mp = 16777215;
		set_regs(lo, hi, ma, md, mp);
		hold_req = 1;
		calm = 1;
		random_run(150);
		calm = 0;
		random_run(150);

		// stretch with no idling at all, then one with random gaps
		drain();
		set_regs(-2200, -800, 3727379, 1875613, 5601518);
		calm = 1;
		random_run(200);
		calm = 0;
		random_run(150);

		drain();
		if (errors == 0) $display("[two_body_invariant_mass_excitation] OK");
		else $display("[two_body_invariant_mass_excitation] ERROR");
		$finish;
	end

endmodule
